// ===== sv/safr_pkg.sv =====
// Shared types, constants and helpers of the serial adapter frame receiver.
package safr_pkg;

  localparam int MAX_FRAME_BYTES = 32;
  localparam int COUNT_W         = 6;
  localparam int INDEX_W         = 5;

  localparam logic [7:0] SYNC_BYTE   = 8'haa;
  localparam logic [7:0] CMD_TYPE    = 8'h55;
  localparam logic [3:0] DATA_NIBBLE = 4'hc;
  localparam int         CMD_LEN     = 20;
  localparam int         DATA_EXTRA  = 5;

  localparam logic [COUNT_W-1:0] CMD_LAST_IDX = COUNT_W'(CMD_LEN - 1);
  localparam logic [COUNT_W-1:0] DATA_LAST_OFS = COUNT_W'(DATA_EXTRA - 1);
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAME_BYTES);

  typedef enum logic [1:0] {
    KIND_UNSYNCED = 2'd0,
    KIND_COMMAND  = 2'd1,
    KIND_DATA     = 2'd2,
    KIND_UNKNOWN  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]         byte_out;
    logic [INDEX_W-1:0] byte_index;
    logic               frame_end;
    kind_t              frame_kind;
    status_t            status;
  } result_t;

  function automatic kind_t kind_of(input logic [7:0] t);
    kind_t k;
    if (t == CMD_TYPE) begin
      k = KIND_COMMAND;
    end else if (t[7:4] == DATA_NIBBLE) begin
      k = KIND_DATA;
    end else begin
      k = KIND_UNKNOWN;
    end
    return k;
  endfunction

endpackage

// ===== sv/safr_core.sv =====
// Frame state and per-byte decode of the serial adapter frame receiver.
module safr_core
  import safr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output result_t    result
);

  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic [7:0]         type_byte;
  logic [7:0]         type_byte_next;
  logic [7:0]         running_sum;
  logic [7:0]         running_sum_next;

  kind_t              kind;
  kind_t              stored_kind;
  logic               frame_end;
  status_t            status;
  logic [COUNT_W-1:0] data_last;

  assign stored_kind = kind_of(type_byte);
  assign data_last   = {2'b00, type_byte[3:0]} + DATA_LAST_OFS;

  always_comb begin
    kind             = KIND_UNSYNCED;
    frame_end        = 1'b0;
    status           = ST_OK;
    type_byte_next   = type_byte;
    running_sum_next = running_sum;
    if (byte_count >= MAX_COUNT) begin
      kind      = (byte_count >= COUNT_W'(2)) ? stored_kind : KIND_UNSYNCED;
      frame_end = 1'b1;
      status    = ST_OVERFLOW;
    end else if (byte_count == '0) begin
      frame_end = (rx_byte != SYNC_BYTE);
    end else if (byte_count == COUNT_W'(1)) begin
      kind           = kind_of(rx_byte);
      type_byte_next = rx_byte;
      frame_end      = (kind == KIND_UNKNOWN);
    end else begin
      kind = stored_kind;
      unique case (stored_kind)
        KIND_COMMAND: begin
          if (byte_count >= CMD_LAST_IDX) begin
            frame_end = 1'b1;
            status    = (rx_byte == running_sum) ? ST_OK : ST_CHECKSUM;
          end else begin
            running_sum_next = running_sum + rx_byte;
          end
        end
        KIND_DATA: begin
          frame_end = (byte_count >= data_last);
        end
        default: begin
          frame_end = 1'b1;
        end
      endcase
    end
    byte_count_next = byte_count + COUNT_W'(1);
    if (frame_end) begin
      byte_count_next  = '0;
      type_byte_next   = '0;
      running_sum_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      type_byte   <= '0;
      running_sum <= '0;
    end else if (step) begin
      byte_count  <= byte_count_next;
      type_byte   <= type_byte_next;
      running_sum <= running_sum_next;
    end
  end

  assign result.byte_out   = rx_byte;
  assign result.byte_index = byte_count[INDEX_W-1:0];
  assign result.frame_end  = frame_end;
  assign result.frame_kind = kind;
  assign result.status     = status;

endmodule

// ===== sv/serial_adapter_frame_receiver_unit.sv =====
// Top level of the serial adapter frame receiver.
// Takes one received serial byte per request on the s_ side and gives one
// result per byte on the m_ side: the byte, its index in the frame, the
// frame kind and, on the last byte of a frame, its status.
// Frames: 0xaa sync, then a type byte; 0x55 gives a 20-byte command frame
// with an 8-bit sum check, 0xcN a data frame of N + 5 bytes, anything else
// a two-byte unknown frame; a stray first byte is a one-byte frame.
// m_tlast marks the byte that ends a frame.
// A result reaches m_ via the input register, then the result register.
// Throughput: one byte per cycle while m_tready is high; the frame counter
// and running sum update on the step that loads the result register.
// Reset (rst, synchronous) empties both registers and returns the framer to
// wait for a sync byte.
// When m_tready is low a result is held in the result register and one more
// byte is still taken into the input register; s_tready then drops.
module serial_adapter_frame_receiver_unit
  import safr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] byte_out, [12:8] byte_index, zero above
  output logic        m_tlast,   // frame_end
  output logic [3:0]  m_tuser    // [1:0] frame_kind, [3:2] status
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  result_t    out_res;
  result_t    core_res;
  logic       out_free;
  logic       step;

  assign out_free = !out_valid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  safr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
    if (step) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res.byte_index, out_res.byte_out};
  assign m_tlast  = out_res.frame_end;
  assign m_tuser  = {out_res.status, out_res.frame_kind};

endmodule
